/* rtl/agm_pkg.sv */
// Shared types, step addresses and the control program of the
// arithmetic-geometric mean unit. Depends on nothing.
package agm_pkg;

  localparam int unsigned ValueW = 48;
  localparam int unsigned MagW   = ValueW - 1;
  localparam int unsigned ProdW  = 2 * MagW;
  localparam int unsigned RemW   = MagW + 3;
  localparam int unsigned CntW   = 6;
  localparam int unsigned LimitW = 7;
  localparam int unsigned GapW   = 16;
  localparam int unsigned PcW    = 4;

  localparam logic [CntW-1:0]   LastBit    = CntW'(MagW - 1);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(100);
  localparam logic [GapW-1:0]   GapReset   = '0;

  localparam logic REG_ROUND_LIMIT = 1'b0;
  localparam logic REG_STOP_GAP    = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_UPDATE,
    OP_OUT_ZERO,
    OP_OUT_LIMIT,
    OP_OUT_CONV
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_ZERO,
    COND_ROUND_END,
    COND_CNT_NZ,
    COND_GAP_OK
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic zero;
    logic round_end;
    logic cnt_nz;
    logic gap_ok;
  } status_t;

  localparam logic [PcW-1:0] STEP_WAIT     = 4'd0;
  localparam logic [PcW-1:0] STEP_ZCHK     = 4'd1;
  localparam logic [PcW-1:0] STEP_RCHK     = 4'd2;
  localparam logic [PcW-1:0] STEP_MUL_INIT = 4'd3;
  localparam logic [PcW-1:0] STEP_MUL      = 4'd4;
  localparam logic [PcW-1:0] STEP_SQ_INIT  = 4'd5;
  localparam logic [PcW-1:0] STEP_SQ       = 4'd6;
  localparam logic [PcW-1:0] STEP_UPDATE   = 4'd7;
  localparam logic [PcW-1:0] STEP_GAP      = 4'd8;
  localparam logic [PcW-1:0] STEP_LOOP     = 4'd9;
  localparam logic [PcW-1:0] STEP_OZERO    = 4'd10;
  localparam logic [PcW-1:0] STEP_OLIMIT   = 4'd11;
  localparam logic [PcW-1:0] STEP_OCONV    = 4'd12;

  function automatic ctrl_t program_word(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT};
    case (pc)
      STEP_WAIT:     w = '{op: OP_LOAD,      cond: COND_NO_START,  target: STEP_WAIT};
      STEP_ZCHK:     w = '{op: OP_INIT,      cond: COND_ZERO,      target: STEP_OZERO};
      STEP_RCHK:     w = '{op: OP_NOP,       cond: COND_ROUND_END, target: STEP_OLIMIT};
      STEP_MUL_INIT: w = '{op: OP_MUL_INIT,  cond: COND_NEVER,     target: STEP_WAIT};
      STEP_MUL:      w = '{op: OP_MUL_STEP,  cond: COND_CNT_NZ,    target: STEP_MUL};
      STEP_SQ_INIT:  w = '{op: OP_SQ_INIT,   cond: COND_NEVER,     target: STEP_WAIT};
      STEP_SQ:       w = '{op: OP_SQ_STEP,   cond: COND_CNT_NZ,    target: STEP_SQ};
      STEP_UPDATE:   w = '{op: OP_UPDATE,    cond: COND_NEVER,     target: STEP_WAIT};
      STEP_GAP:      w = '{op: OP_NOP,       cond: COND_GAP_OK,    target: STEP_OCONV};
      STEP_LOOP:     w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: STEP_RCHK};
      STEP_OZERO:    w = '{op: OP_OUT_ZERO,  cond: COND_ALWAYS,    target: STEP_WAIT};
      STEP_OLIMIT:   w = '{op: OP_OUT_LIMIT, cond: COND_ALWAYS,    target: STEP_WAIT};
      STEP_OCONV:    w = '{op: OP_OUT_CONV,  cond: COND_ALWAYS,    target: STEP_WAIT};
      default:       w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [MagW-1:0] magnitude(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] neg;
    neg = (~v) + ValueW'(1);
    if (!v[ValueW-1]) begin
      return v[MagW-1:0];
    end else if (v[MagW-1:0] == '0) begin
      return {MagW{1'b1}};
    end else begin
      return neg[MagW-1:0];
    end
  endfunction

endpackage

/* rtl/agm_seq.sv */
// Step counter and control program of the arithmetic-geometric mean unit.
// Depends on agm_pkg for the control word, the status group and the program.
module agm_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  agm_pkg::status_t status_i,
  output agm_pkg::ctrl_t  ctrl_o,
  output logic            busy
);
  import agm_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ctrl_t          word;
  logic           take;

  assign word   = program_word(pc_q);
  assign ctrl_o = word;
  assign busy   = (pc_q != STEP_WAIT);

  always_comb begin
    case (word.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !start;
      COND_ZERO:      take = status_i.zero;
      COND_ROUND_END: take = status_i.round_end;
      COND_CNT_NZ:    take = status_i.cnt_nz;
      COND_GAP_OK:    take = status_i.gap_ok;
      default:        take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_accept_goes_to_zero_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_WAIT && start) |=> (pc_q == STEP_ZCHK))
    else $error("Accepted item did not enter the zero check.");

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= STEP_OCONV)
    else $error("Step counter left the program.");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_WAIT && !start) |=> (pc_q == STEP_WAIT))
    else $error("Sequencer left idle without a start.");

endmodule

/* rtl/agm_datapath.sv */
// Operand, shift-add multiplier and restoring square root registers, plus the
// configuration registers and the result register. Depends on agm_pkg.
module agm_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  agm_pkg::ctrl_t              ctrl_i,
  input  logic [agm_pkg::ValueW-1:0]  first_value_i,
  input  logic [agm_pkg::ValueW-1:0]  second_value_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [agm_pkg::GapW-1:0]    cfg_wdata_i,
  output agm_pkg::status_t            status_o,
  output logic [agm_pkg::MagW-1:0]    mean_o,
  output logic                        converged_o,
  output logic                        done_o
);
  import agm_pkg::*;

  logic [MagW-1:0]   a_q, a_d, b_q, b_d, root_q, root_d, mean_q, mean_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [RemW-1:0]   rem_q, rem_d, rem_sh, trial;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LimitW-1:0] rnd_q, rnd_d, limit_q;
  logic [GapW-1:0]   gap_q;
  logic              conv_q, conv_d, done_q, done_d;
  logic [MagW:0]     pair_sum, mul_sum;
  logic [MagW-1:0]   diff;

  assign pair_sum = {1'b0, a_q} + {1'b0, b_q};
  assign mul_sum  = {1'b0, prod_q[ProdW-1:MagW]} + (prod_q[0] ? {1'b0, a_q} : '0);
  assign rem_sh   = {rem_q[RemW-3:0], prod_q[ProdW-1:ProdW-2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign diff     = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);

  assign status_o.zero      = (a_q == '0) || (b_q == '0);
  assign status_o.round_end = (rnd_q == limit_q);
  assign status_o.cnt_nz    = (cnt_q != '0);
  assign status_o.gap_ok    = (diff <= {{(MagW-GapW){1'b0}}, gap_q});

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    rnd_d  = rnd_q;
    mean_d = mean_q;
    conv_d = conv_q;
    done_d = 1'b0;
    case (ctrl_i.op)
      OP_LOAD: begin
        a_d = magnitude(first_value_i);
        b_d = magnitude(second_value_i);
      end
      OP_INIT: rnd_d = '0;
      OP_MUL_INIT: begin
        prod_d = {{MagW{1'b0}}, b_q};
        cnt_d  = LastBit;
      end
      OP_MUL_STEP: begin
        prod_d = {mul_sum, prod_q[MagW-1:1]};
        cnt_d  = cnt_q - CntW'(1);
      end
      OP_SQ_INIT: begin
        rem_d  = '0;
        root_d = '0;
        cnt_d  = LastBit;
      end
      OP_SQ_STEP: begin
        prod_d = {prod_q[ProdW-3:0], 2'b00};
        cnt_d  = cnt_q - CntW'(1);
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[MagW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[MagW-2:0], 1'b0};
        end
      end
      OP_UPDATE: begin
        a_d   = pair_sum[MagW:1];
        b_d   = root_q;
        rnd_d = rnd_q + LimitW'(1);
      end
      OP_OUT_ZERO: begin
        mean_d = '0;
        conv_d = 1'b1;
        done_d = 1'b1;
      end
      OP_OUT_LIMIT: begin
        mean_d = pair_sum[MagW:1];
        conv_d = 1'b0;
        done_d = 1'b1;
      end
      OP_OUT_CONV: begin
        mean_d = pair_sum[MagW:1];
        conv_d = 1'b1;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    mean_q <= mean_d;
    conv_q <= conv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rnd_q   <= '0;
      done_q  <= 1'b0;
      limit_q <= LimitReset;
      gap_q   <= GapReset;
    end else begin
      cnt_q  <= cnt_d;
      rnd_q  <= rnd_d;
      done_q <= done_d;
      if (cfg_we_i && cfg_idx_i == REG_ROUND_LIMIT) begin
        limit_q <= cfg_wdata_i[LimitW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_STOP_GAP) begin
        gap_q <= cfg_wdata_i;
      end
    end
  end

  assign mean_o      = mean_q;
  assign converged_o = conv_q;
  assign done_o      = done_q;

  a_zero_mean_is_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && mean_q == '0) |-> conv_q)
    else $error("Zero mean reported without convergence.");

  a_step_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_MUL_STEP || ctrl_i.op == OP_SQ_STEP) |-> (cnt_q <= LastBit))
    else $error("Bit counter out of range during a serial step.");

endmodule

/* rtl/arithmetic_geometric_mean_unit.sv */
// Arithmetic-geometric mean unit, top level. Uses agm_pkg, agm_seq and agm_datapath.
// A zero operand skips the rounds; otherwise rounds run until the gap test passes or the round limit is hit.
// Each round runs the 47-step shift-add multiply and the 47-step restoring root.
// Throughput: one item at a time; a new start is taken in the cycle done_o shows a result.
// Reset clears the sequencer and sets round_limit to 100 and stop_gap to 0.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
module arithmetic_geometric_mean_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [agm_pkg::ValueW-1:0]  first_value_i,
  input  logic [agm_pkg::ValueW-1:0]  second_value_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [agm_pkg::GapW-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic [agm_pkg::MagW-1:0]    mean_o,
  output logic                        converged_o
);
  import agm_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  agm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  agm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .status_o       (status),
    .mean_o         (mean_o),
    .converged_o    (converged_o),
    .done_o         (done_o)
  );

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("Result strobe without an item in progress.");

endmodule
